### rtl/clrd_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// clrd_pkg
// shared types and constants for the compressed log record decoder
// ---------------------------------------------------------------------------
package clrd_pkg;

    // largest argument count a header may carry (1 to 7)
    localparam int MAX_ARGS  = 4;
    // argument words that are kept and reported
    localparam int ARG_SLOTS = 4;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_ID     = 4'b0010,
        PH_DELTA  = 4'b0100,
        PH_ARGS   = 4'b1000
    } phase_t;

    typedef logic [ARG_SLOTS-1:0][31:0] arg_words_t;

    typedef struct packed {
        logic [31:0] format_id;
        logic [63:0] delta_cycles;
        logic [63:0] total_cycles;
        arg_words_t  arg_words;
        logic [2:0]  arg_count;
        logic        header_error;
    } rec_t;

endpackage
`default_nettype wire

### rtl/clrd_parser.sv
`default_nettype none
// ---------------------------------------------------------------------------
// clrd_parser
// byte parser: assembles header, format id, delta and argument words and
// produces a record when a record's last byte or a bad-count header arrives
// ---------------------------------------------------------------------------
module clrd_parser (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          byte_fire,
    input  wire logic [7:0]    log_byte,
    output logic               rec_fire,
    output clrd_pkg::rec_t     rec_data
);

    clrd_pkg::phase_t     phase_reg, phase_next;
    logic [4:0]           bytes_left_reg, bytes_left_next;
    logic [7:0]           header_reg, header_next;
    logic [31:0]          id_reg, id_next;
    logic [63:0]          delta_reg, delta_next;
    clrd_pkg::arg_words_t args_reg, args_next;
    logic [63:0]          total_reg, total_next;

    logic [2:0] n_hdr;
    logic [4:0] len;
    logic [4:0] pos;
    logic       finish;

    assign n_hdr = header_reg[7:5];

    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        header_next     = header_reg;
        id_next         = id_reg;
        delta_next      = delta_reg;
        args_next       = args_reg;
        total_next      = total_reg;
        rec_fire        = 1'b0;
        rec_data        = '0;
        finish          = 1'b0;
        len             = '0;
        pos             = '0;

        if (byte_fire)
        begin
            case (phase_reg)
                clrd_pkg::PH_HEADER:
                begin
                    header_next = log_byte;
                    id_next     = '0;
                    delta_next  = '0;
                    args_next   = '0;
                    if (log_byte[7:5] > 3'(clrd_pkg::MAX_ARGS))
                    begin
                        // bad count: report at once and wait for a new header
                        rec_fire              = 1'b1;
                        rec_data.total_cycles = total_reg;
                        rec_data.arg_count    = log_byte[7:5];
                        rec_data.header_error = 1'b1;
                        phase_next            = clrd_pkg::PH_HEADER;
                        bytes_left_next       = '0;
                    end
                    else
                    begin
                        phase_next      = clrd_pkg::PH_ID;
                        bytes_left_next = {3'b000, log_byte[1:0]} + 5'd1;
                    end
                end

                clrd_pkg::PH_ID:
                begin
                    len = {3'b000, header_reg[1:0]} + 5'd1;
                    pos = len - bytes_left_reg;
                    for (int i = 0; i < 4; i++)
                    begin
                        if (pos[1:0] == 2'(i))
                            id_next[8*i +: 8] = id_reg[8*i +: 8] | log_byte;
                    end
                    bytes_left_next = bytes_left_reg - 5'd1;
                    if (bytes_left_reg == 5'd1)
                    begin
                        phase_next      = clrd_pkg::PH_DELTA;
                        bytes_left_next = {2'b00, header_reg[4:2]} + 5'd1;
                    end
                end

                clrd_pkg::PH_DELTA:
                begin
                    len = {2'b00, header_reg[4:2]} + 5'd1;
                    pos = len - bytes_left_reg;
                    for (int i = 0; i < 8; i++)
                    begin
                        if (pos[2:0] == 3'(i))
                            delta_next[8*i +: 8] = delta_reg[8*i +: 8] | log_byte;
                    end
                    bytes_left_next = bytes_left_reg - 5'd1;
                    if (bytes_left_reg == 5'd1)
                    begin
                        if (n_hdr == 3'd0)
                            finish = 1'b1;
                        else
                        begin
                            phase_next      = clrd_pkg::PH_ARGS;
                            bytes_left_next = {n_hdr, 2'b00};
                        end
                    end
                end

                clrd_pkg::PH_ARGS:
                begin
                    len = {n_hdr, 2'b00};
                    pos = len - bytes_left_reg;
                    // words past the kept slots are consumed and dropped
                    for (int i = 0; i < clrd_pkg::ARG_SLOTS; i++)
                    begin
                        for (int j = 0; j < 4; j++)
                        begin
                            if (pos[4:2] == 3'(i) && pos[1:0] == 2'(j))
                                args_next[i][8*j +: 8] = args_reg[i][8*j +: 8] | log_byte;
                        end
                    end
                    bytes_left_next = bytes_left_reg - 5'd1;
                    if (bytes_left_reg == 5'd1)
                        finish = 1'b1;
                end

                default:
                begin
                    phase_next      = clrd_pkg::PH_HEADER;
                    bytes_left_next = '0;
                end
            endcase

            if (finish)
            begin
                total_next            = total_reg + delta_next;
                rec_fire              = 1'b1;
                rec_data.format_id    = id_next;
                rec_data.delta_cycles = delta_next;
                rec_data.total_cycles = total_next;
                rec_data.arg_words    = args_next;
                rec_data.arg_count    = n_hdr;
                rec_data.header_error = 1'b0;
                phase_next            = clrd_pkg::PH_HEADER;
                bytes_left_next       = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= clrd_pkg::PH_HEADER;
            bytes_left_reg <= '0;
            header_reg     <= '0;
            id_reg         <= '0;
            delta_reg      <= '0;
            args_reg       <= '0;
            total_reg      <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            header_reg     <= header_next;
            id_reg         <= id_next;
            delta_reg      <= delta_next;
            args_reg       <= args_next;
            total_reg      <= total_next;
        end
    end

endmodule
`default_nettype wire

### rtl/clrd_out_buf.sv
`default_nettype none
// ---------------------------------------------------------------------------
// clrd_out_buf
// result register with a skid stage so the byte side keeps flowing while a
// finished record waits to be taken
// ---------------------------------------------------------------------------
module clrd_out_buf (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire clrd_pkg::rec_t push_rec,
    output logic                full,
    output logic                rec_valid,
    input  wire logic           rec_stall,
    output clrd_pkg::rec_t      rec_out
);

    logic           main_valid_reg, main_valid_next;
    logic           skid_valid_reg, skid_valid_next;
    clrd_pkg::rec_t main_reg, main_next;
    clrd_pkg::rec_t skid_reg, skid_next;
    logic           pop;

    assign pop       = main_valid_reg && !rec_stall;
    assign full      = skid_valid_reg;
    assign rec_valid = main_valid_reg;
    assign rec_out   = main_reg;

    // push only arrives while the skid stage is empty
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
                main_next = push_rec;
            else
                main_valid_next = 1'b0;
        end
        else if (push)
        begin
            if (!main_valid_reg)
            begin
                main_next       = push_rec;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_rec;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule
`default_nettype wire

### rtl/compressed_log_record_decoder_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// compressed_log_record_decoder_core
// decodes a compressed trace log, one byte per transaction, into records
// ---------------------------------------------------------------------------
// The block takes one log byte every cycle and never stalls the byte side
// unless two decoded records are waiting on the record side. A record is
// registered in the output buffer when its last byte is taken (when the
// header byte is taken if the header asks for more than four arguments,
// with header_error set). The parser takes in each byte as it arrives, and
// adds the 64-bit running total in the same cycle as a record's last byte.
// ---------------------------------------------------------------------------
module compressed_log_record_decoder_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        log_valid,
    output logic             log_stall,
    input  wire logic [7:0]  log_byte,
    output logic             rec_valid,
    input  wire logic        rec_stall,
    output logic [31:0]      format_id,
    output logic [63:0]      delta_cycles,
    output logic [63:0]      total_cycles,
    output logic [31:0]      arg_zero,
    output logic [31:0]      arg_one,
    output logic [31:0]      arg_two,
    output logic [31:0]      arg_three,
    output logic [2:0]       arg_count,
    output logic             header_error
);

    logic           byte_fire;
    logic           rec_fire;
    logic           buf_full;
    clrd_pkg::rec_t rec_data;
    clrd_pkg::rec_t rec_out;

    assign log_stall = buf_full;
    assign byte_fire = log_valid && !buf_full;

    clrd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_fire (byte_fire),
        .log_byte  (log_byte),
        .rec_fire  (rec_fire),
        .rec_data  (rec_data)
    );

    clrd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rec_fire),
        .push_rec  (rec_data),
        .full      (buf_full),
        .rec_valid (rec_valid),
        .rec_stall (rec_stall),
        .rec_out   (rec_out)
    );

    assign format_id    = rec_out.format_id;
    assign delta_cycles = rec_out.delta_cycles;
    assign total_cycles = rec_out.total_cycles;
    assign arg_zero     = rec_out.arg_words[0];
    assign arg_one      = rec_out.arg_words[1];
    assign arg_two      = rec_out.arg_words[2];
    assign arg_three    = rec_out.arg_words[3];
    assign arg_count    = rec_out.arg_count;
    assign header_error = rec_out.header_error;

endmodule
`default_nettype wire

### tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the compressed log record decoder: a queue of log
// bytes feeds a clocked driver, every accepted byte runs through a local
// record decoder, and a clocked monitor compares each record transaction
// against the oldest predicted record, with random gaps and stalls
// ---------------------------------------------------------------------------
module tb_top;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_BYTES = 590;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        log_valid = 1'b0;
    logic        log_stall;
    logic [7:0]  log_byte = 8'h00;
    logic        rec_valid;
    logic        rec_stall = 1'b0;
    logic [31:0] format_id;
    logic [63:0] delta_cycles;
    logic [63:0] total_cycles;
    logic [31:0] arg_zero;
    logic [31:0] arg_one;
    logic [31:0] arg_two;
    logic [31:0] arg_three;
    logic [2:0]  arg_count;
    logic        header_error;

    compressed_log_record_decoder_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .log_valid    (log_valid),
        .log_stall    (log_stall),
        .log_byte     (log_byte),
        .rec_valid    (rec_valid),
        .rec_stall    (rec_stall),
        .format_id    (format_id),
        .delta_cycles (delta_cycles),
        .total_cycles (total_cycles),
        .arg_zero     (arg_zero),
        .arg_one      (arg_one),
        .arg_two      (arg_two),
        .arg_three    (arg_three),
        .arg_count    (arg_count),
        .header_error (header_error)
    );

    always #CLK_HALF clk = ~clk;

    logic [7:0]     byte_queue[$];
    clrd_pkg::rec_t pending_records[$];
    int             err_count = 0;
    int             cycle_count = 0;

    // decoder shadow state
    clrd_pkg::phase_t     rx_phase = clrd_pkg::PH_HEADER;
    int                   rx_left = 0;
    logic [7:0]           rx_header = 8'h00;
    logic [31:0]          rx_id = '0;
    logic [63:0]          rx_delta = '0;
    clrd_pkg::arg_words_t rx_args = '0;
    logic [63:0]          rx_total = '0;

    int send_gap = 0;
    int send_quiet = 0;
    int recv_gap = 0;
    int recv_quiet = 0;

    // mostly short gaps, a few long ones, and now and then a stretch with none
    function automatic int pick_gap(inout int quiet);
        int r;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            quiet = $urandom_range(20, 80);
            return 0;
        end
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic close_record();
        clrd_pkg::rec_t r;
        rx_total = rx_total + rx_delta;
        r.format_id    = rx_id;
        r.delta_cycles = rx_delta;
        r.total_cycles = rx_total;
        r.arg_words    = rx_args;
        r.arg_count    = rx_header[7:5];
        r.header_error = 1'b0;
        pending_records.push_back(r);
        rx_phase = clrd_pkg::PH_HEADER;
        rx_left  = 0;
    endtask

    task automatic decode_log_byte(input logic [7:0] b);
        clrd_pkg::rec_t r;
        int   n;
        int   pos;
        int   w;
        n = int'(rx_header[7:5]);
        case (rx_phase)
            clrd_pkg::PH_HEADER: begin
                rx_header = b;
                rx_id     = '0;
                rx_delta  = '0;
                rx_args   = '0;
                n = int'(b[7:5]);
                if (n > clrd_pkg::MAX_ARGS) begin
                    // oversized count: flagged record right away, then a new header
                    r = '0;
                    r.total_cycles = rx_total;
                    r.arg_count    = b[7:5];
                    r.header_error = 1'b1;
                    pending_records.push_back(r);
                    rx_left = 0;
                end else begin
                    rx_phase = clrd_pkg::PH_ID;
                    rx_left  = b[1:0] + 1;
                end
            end
            clrd_pkg::PH_ID: begin
                pos = (rx_header[1:0] + 1) - rx_left;
                rx_id[8*pos +: 8] = b;
                rx_left--;
                if (rx_left == 0) begin
                    rx_phase = clrd_pkg::PH_DELTA;
                    rx_left  = rx_header[4:2] + 1;
                end
            end
            clrd_pkg::PH_DELTA: begin
                pos = (rx_header[4:2] + 1) - rx_left;
                rx_delta[8*pos +: 8] = b;
                rx_left--;
                if (rx_left == 0) begin
                    if (n == 0)
                        close_record();
                    else begin
                        rx_phase = clrd_pkg::PH_ARGS;
                        rx_left  = 4 * n;
                    end
                end
            end
            default: begin
                pos = 4 * n - rx_left;
                w   = pos / 4;
                if (w < clrd_pkg::ARG_SLOTS)
                    rx_args[w][8*(pos%4) +: 8] = b;
                rx_left--;
                if (rx_left == 0)
                    close_record();
            end
        endcase
    endtask

    function automatic logic [31:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'h0000_0000;
        if (r == 1)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    task automatic queue_record(input logic [7:0] hdr, input logic [31:0] id,
                                input logic [63:0] delta,
                                input clrd_pkg::arg_words_t args);
        int          cnt;
        logic [31:0] word;
        byte_queue.push_back(hdr);
        cnt = int'(hdr[7:5]);
        if (cnt > clrd_pkg::MAX_ARGS)
            return;
        for (int i = 0; i <= hdr[1:0]; i++)
            byte_queue.push_back(id[8*i +: 8]);
        for (int i = 0; i <= hdr[4:2]; i++)
            byte_queue.push_back(delta[8*i +: 8]);
        for (int w = 0; w < cnt; w++) begin
            word = (w < clrd_pkg::ARG_SLOTS) ? args[w] : pick_word();
            for (int i = 0; i < 4; i++)
                byte_queue.push_back(word[8*i +: 8]);
        end
    endtask

    task automatic queue_random_record();
        logic [7:0]           hdr;
        clrd_pkg::arg_words_t args;
        logic [63:0]          delta;
        hdr = 8'($urandom);
        if ($urandom_range(0, 9) != 0)
            hdr[7:5] = 3'($urandom_range(0, clrd_pkg::MAX_ARGS));
        for (int w = 0; w < clrd_pkg::ARG_SLOTS; w++)
            args[w] = pick_word();
        delta = {pick_word(), pick_word()};
        queue_record(hdr, pick_word(), delta, args);
    endtask

    // byte driver
    always @(posedge clk) begin : drv
        logic next_valid;
        if (rst_n) begin
            next_valid = log_valid;
            if (log_valid && !log_stall) begin
                decode_log_byte(log_byte);
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (send_gap > 0)
                    send_gap--;
                else if (byte_queue.size() > 0) begin
                    log_byte  <= byte_queue.pop_front();
                    next_valid = 1'b1;
                    send_gap   = pick_gap(send_quiet);
                end
            end
            log_valid <= next_valid;
        end
    end

    task automatic check_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] act_val);
        if (exp_val !== act_val) begin
            err_count++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_val, act_val);
        end
    endtask

    // record monitor
    always @(posedge clk) begin : mon
        clrd_pkg::rec_t e;
        if (rst_n) begin
            if (rec_valid && !rec_stall) begin
                if (pending_records.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected record, expected none, got id %h total %h",
                             $time, format_id, total_cycles);
                end else begin
                    e = pending_records.pop_front();
                    check_field("format_id", 64'(e.format_id), 64'(format_id));
                    check_field("delta_cycles", e.delta_cycles, delta_cycles);
                    check_field("total_cycles", e.total_cycles, total_cycles);
                    check_field("arg_zero", 64'(e.arg_words[0]), 64'(arg_zero));
                    check_field("arg_one", 64'(e.arg_words[1]), 64'(arg_one));
                    check_field("arg_two", 64'(e.arg_words[2]), 64'(arg_two));
                    check_field("arg_three", 64'(e.arg_words[3]), 64'(arg_three));
                    check_field("arg_count", 64'(e.arg_count), 64'(arg_count));
                    check_field("header_error", 64'(e.header_error), 64'(header_error));
                end
            end
            if (recv_gap > 0) begin
                rec_stall <= 1'b1;
                recv_gap--;
            end else begin
                rec_stall <= 1'b0;
                recv_gap = pick_gap(recv_quiet);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        int base;
        int r;
        // smallest record, then widest fields at their extremes
        queue_record(8'h00, 32'h0, 64'h0, '0);
        queue_record(8'h1F, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, '0);
        // total wraps past 64 bits
        queue_record(8'h00, 32'h5A, 64'h1, '0);
        queue_record(8'h9F, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                     {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        queue_record(8'h80, 32'h11, 64'h22,
                     {32'h1314_1516, 32'h0D0E_0F10, 32'h0708_090A, 32'h0102_0304});
        queue_record(8'h21, 32'hA5C3, 64'h7F, {96'h0, 32'h8000_0001});
        queue_record(8'h46, 32'h00AB_CDEF, 64'h0102_0304_0506,
                     {64'h0, 32'hDEAD_BEEF, 32'h0000_0001});
        queue_record(8'h6B, 32'h0102_0304, 64'h00FF_00FF,
                     {32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF});
        // oversized argument counts, each flagged from the header alone
        queue_record(8'hA0, 32'h0, 64'h0, '0);
        queue_record(8'hC0, 32'h0, 64'h0, '0);
        queue_record(8'hFF, 32'h0, 64'h0, '0);
        queue_record(8'hE3, 32'h0, 64'h0, '0);
        queue_record(8'h7C, 32'hCAFE, 64'h8000_0000_0000_0000,
                     {32'h0, 32'h5555_AAAA, 32'hAAAA_5555, 32'h1234_5678});
        queue_record(8'h9C, 32'h42, 64'h8000_0000_0000_0000,
                     {32'h8765_4321, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000});

        base = byte_queue.size();
        while (byte_queue.size() < base + RANDOM_BYTES) begin
            r = $urandom_range(0, 99);
            if (r < 85)
                queue_random_record();
            else if (r < 95)
                byte_queue.push_back({3'($urandom_range(clrd_pkg::MAX_ARGS + 1, 7)),
                                      5'($urandom)});
            else begin
                // loose bytes that throw the parse off its record boundaries
                repeat ($urandom_range(1, 3))
                    byte_queue.push_back(8'($urandom));
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (byte_queue.size() > 0 || log_valid || pending_records.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (err_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

### filelist.f
rtl/clrd_pkg.sv
rtl/clrd_parser.sv
rtl/clrd_out_buf.sv
rtl/compressed_log_record_decoder_core.sv
tb/tb_top.sv
